// ===== sv/parent_linked_key_table_assert.svh =====
// Assertion macros shared by the checker.
`ifndef PARENT_LINKED_KEY_TABLE_ASSERT_SVH
`define PARENT_LINKED_KEY_TABLE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLKT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plkt assertion failed");

// Next-cycle implication, disabled during reset.
`define PLKT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plkt assertion failed");

`endif

// ===== sv/plkt_pkg.sv =====
`timescale 1ns / 1ps
package plkt_pkg;

    localparam int CMD_W   = 3;
    localparam int KEY_W   = 32;
    localparam int INFO_W  = 16;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 5;
    localparam int CAP_W   = 6;
    localparam int ENTRY_W = 2 * KEY_W + INFO_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    // request commands
    localparam logic [CMD_W-1:0] OP_ADD     = 3'd0;
    localparam logic [CMD_W-1:0] OP_FIND    = 3'd1;
    localparam logic [CMD_W-1:0] OP_DELETE  = 3'd2;
    localparam logic [CMD_W-1:0] OP_COMPACT = 3'd3;
    localparam logic [CMD_W-1:0] OP_SHOW    = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_PARENT = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;

    // where the entry fields of a result come from
    typedef enum logic [1:0] {EK_NONE, EK_INPUT, EK_FOUND, EK_RAM} emit_kind_t;

    // where the slot index of a result comes from
    typedef enum logic [1:0] {SS_ZERO, SS_FILL, SS_FOUND, SS_IDX} slot_sel_t;

    typedef struct packed {
        logic              latch;
        logic              idx_clr;
        logic              idx_inc;
        logic              rd_en;
        logic              rd_last;
        logic              cmp_arm;
        logic              add_wr;
        logic              del_kill;
        logic              mov_wr;
        logic              fill_dec;
        logic              emit;
        logic [STAT_W-1:0] emit_status;
        emit_kind_t        emit_kind;
        slot_sel_t         slot_sel;
        logic              emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fill_zero;
        logic idx_at_fill;
        logic cmp_pend;
        logic found;
        logic par_found;
        logic par_zero;
        logic full;
        logic live_idx;
        logic any_live;
        logic last_live;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/plkt_req_if.sv =====
`timescale 1ns / 1ps
interface plkt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] entry_key_in;
    logic [31:0] parent_key_in;
    logic [15:0] info_handle_in;

    modport source (output valid, command, entry_key_in, parent_key_in, info_handle_in,
                    input ready);
    modport sink (input valid, command, entry_key_in, parent_key_in, info_handle_in,
                  output ready);
endinterface

// ===== sv/plkt_rsp_if.sv =====
`timescale 1ns / 1ps
interface plkt_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [31:0] out_key;
    logic [31:0] out_parent;
    logic [15:0] out_info;
    logic        entry_valid;
    logic        last_result;

    modport source (output valid, status, slot_index, out_key, out_parent, out_info,
                    entry_valid, last_result, input ready);
    modport sink (input valid, status, slot_index, out_key, out_parent, out_info,
                  entry_valid, last_result, output ready);
endinterface

// ===== sv/plkt_ram.sv =====
`timescale 1ns / 1ps
module plkt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== sv/plkt_ctrl.sv =====
`timescale 1ns / 1ps
module plkt_ctrl import plkt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [CMD_W-1:0] req_command,
    input  dp_stat_t         stat,
    output ctrl_cmd_t        cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DROP   = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_START  = 4'd4;
    localparam logic [3:0] S_CCHK   = 4'd5;
    localparam logic [3:0] S_CMOV   = 4'd6;
    localparam logic [3:0] S_SHCHK  = 4'd7;
    localparam logic [3:0] S_SHEM   = 4'd8;

    logic [3:0]       state_reg, state_next;
    logic [CMD_W-1:0] op_reg, op_next;

    assign req_ready = (state_reg == S_IDLE);

    // next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.latch   = 1'b1;
                    cmd.idx_clr = 1'b1;
                    op_next     = req_command;
                    unique case (req_command)
                        OP_ADD, OP_FIND, OP_DELETE: state_next = S_SCAN;
                        OP_COMPACT, OP_SHOW:        state_next = S_START;
                        default:                    state_next = S_DROP;
                    endcase
                end
            end
            S_DROP:
            begin
                state_next = S_IDLE;
            end
            // read every used slot, compare in the cycle after each read
            S_SCAN:
            begin
                if (!stat.idx_at_fill)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.cmp_arm = 1'b1;
                    cmd.idx_inc = 1'b1;
                end
                else if (!stat.cmp_pend)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = S_IDLE;
                    unique case (op_reg)
                        OP_ADD:
                        begin
                            priority if (stat.found)
                                cmd.emit_status = ST_DUPLICATE;
                            else if (!stat.par_zero && !stat.par_found)
                                cmd.emit_status = ST_NO_PARENT;
                            else if (stat.full)
                                cmd.emit_status = ST_FULL;
                            else
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.add_wr      = 1'b1;
                                cmd.emit_kind   = EK_INPUT;
                                cmd.slot_sel    = SS_FILL;
                            end
                        end
                        OP_FIND:
                        begin
                            if (stat.found)
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.emit_kind   = EK_FOUND;
                                cmd.slot_sel    = SS_FOUND;
                            end
                            else
                            begin
                                cmd.emit_status = ST_NOT_FOUND;
                            end
                        end
                        OP_DELETE:
                        begin
                            priority if (stat.fill_zero)
                                cmd.emit_status = ST_EMPTY;
                            else if (stat.found)
                            begin
                                cmd.emit_status = ST_OK;
                                cmd.del_kill    = 1'b1;
                                cmd.slot_sel    = SS_FOUND;
                            end
                            else
                                cmd.emit_status = ST_NOT_FOUND;
                        end
                        default:
                        begin
                            cmd.emit_status = ST_OK;
                        end
                    endcase
                end
            end
            // empty-table case for compact and show, no-live case for show
            S_START:
            begin
                priority if (stat.fill_zero)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = ST_EMPTY;
                        state_next      = S_IDLE;
                    end
                end
                else if (op_reg == OP_COMPACT)
                begin
                    state_next = S_CCHK;
                end
                else if (!stat.any_live)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = ST_OK;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_SHCHK;
                end
            end
            // compact: pull the last slot into each dead slot
            S_CCHK:
            begin
                priority if (stat.idx_at_fill)
                begin
                    if (stat.out_free)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_last   = 1'b1;
                        cmd.emit_status = ST_OK;
                        state_next      = S_IDLE;
                    end
                end
                else if (stat.live_idx)
                begin
                    cmd.idx_inc = 1'b1;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_last  = 1'b1;
                    cmd.fill_dec = 1'b1;
                    state_next   = S_CMOV;
                end
            end
            S_CMOV:
            begin
                cmd.mov_wr = 1'b1;
                state_next = S_CCHK;
            end
            // show: read each live slot and emit it
            S_SHCHK:
            begin
                priority if (stat.idx_at_fill)
                    state_next = S_IDLE;
                else if (stat.live_idx)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SHEM;
                end
                else
                    cmd.idx_inc = 1'b1;
            end
            S_SHEM:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = ST_OK;
                    cmd.emit_kind   = EK_RAM;
                    cmd.slot_sel    = SS_IDX;
                    cmd.emit_last   = stat.last_live;
                    if (stat.last_live)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SHCHK;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

endmodule

// ===== sv/plkt_dp.sv =====
`timescale 1ns / 1ps
module plkt_dp import plkt_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    input  logic [KEY_W-1:0]  in_key,
    input  logic [KEY_W-1:0]  in_parent,
    input  logic [INFO_W-1:0] in_info,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [STAT_W-1:0] out_status,
    output logic [SLOT_W-1:0] out_slot,
    output logic [KEY_W-1:0]  out_key,
    output logic [KEY_W-1:0]  out_parent,
    output logic [INFO_W-1:0] out_info,
    output logic              out_entry_valid,
    output logic              out_last
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // control state
    logic [CAP_W-1:0]       cap_reg;
    logic [CW-1:0]          fill_reg, fill_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [TABLE_DEPTH-1:0] live_reg, live_next;
    logic [TABLE_DEPTH-1:0] child_reg, child_next;
    logic                   found_reg, found_next;
    logic                   pfound_reg, pfound_next;
    logic                   cmp_vld_reg;
    logic                   out_valid_reg;

    // payload
    logic [KEY_W-1:0]  key_reg, par_reg;
    logic [INFO_W-1:0] info_reg;
    logic [IW-1:0]     cmp_idx_reg;
    logic [IW-1:0]     found_idx_reg, found_idx_next;
    logic [KEY_W-1:0]  fpar_reg, fpar_next;
    logic [INFO_W-1:0] finfo_reg, finfo_next;
    logic [STAT_W-1:0] ostat_reg;
    logic [SLOT_W-1:0] oslot_reg;
    logic [KEY_W-1:0]  okey_reg, opar_reg;
    logic [INFO_W-1:0] oinfo_reg;
    logic              oev_reg, olast_reg;

    // table memory
    logic               ram_we;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [KEY_W-1:0]   rd_key, rd_par;
    logic [INFO_W-1:0]  rd_info;
    logic [CW-1:0]      fill_m1;

    assign fill_m1   = fill_reg - 1'b1;
    assign ram_we    = cmd.add_wr | cmd.mov_wr;
    assign ram_waddr = cmd.add_wr ? fill_reg[IW-1:0] : idx_reg[IW-1:0];
    assign ram_wdata = cmd.add_wr ? {key_reg, par_reg, info_reg} : ram_rdata;
    assign ram_raddr = cmd.rd_last ? fill_m1[IW-1:0] : idx_reg[IW-1:0];
    assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_par    = ram_rdata[INFO_W +: KEY_W];
    assign rd_info   = ram_rdata[INFO_W-1:0];

    plkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // used and above-index masks over the live bits
    logic [TABLE_DEPTH-1:0] used_mask, above_mask;
    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            used_mask[i]  = CW'(i) < fill_reg;
            above_mask[i] = CW'(i) > idx_reg;
        end
    end

    // status toward the controller
    always_comb
    begin
        stat.fill_zero   = (fill_reg == '0);
        stat.idx_at_fill = (idx_reg >= fill_reg);
        stat.cmp_pend    = cmp_vld_reg;
        stat.found       = found_reg;
        stat.par_found   = pfound_reg;
        stat.par_zero    = (par_reg == '0);
        stat.full        = (32'(fill_reg) >= 32'(cap_reg)) || (fill_reg >= CW'(TABLE_DEPTH));
        stat.live_idx    = live_reg[idx_reg[IW-1:0]];
        stat.any_live    = |(live_reg & used_mask);
        stat.last_live   = ~|(live_reg & used_mask & above_mask);
        stat.out_free    = !out_valid_reg || out_ready;
    end

    // scan compare, live bits, counters
    always_comb
    begin
        logic cmp_live;
        logic moved_live;
        cmp_live       = live_reg[cmp_idx_reg];
        moved_live     = live_reg[fill_reg[IW-1:0]];
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        fpar_next      = fpar_reg;
        finfo_next     = finfo_reg;
        pfound_next    = pfound_reg;
        child_next     = child_reg;
        live_next      = live_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;

        if (cmd.latch)
        begin
            found_next  = 1'b0;
            pfound_next = 1'b0;
            child_next  = '0;
        end
        else if (cmp_vld_reg)
        begin
            if (cmp_live && (rd_key == key_reg) && !found_reg)
            begin
                found_next     = 1'b1;
                found_idx_next = cmp_idx_reg;
                fpar_next      = rd_par;
                finfo_next     = rd_info;
            end
            if (cmp_live && (rd_key == par_reg))
                pfound_next = 1'b1;
            if (rd_par == key_reg)
                child_next[cmp_idx_reg] = 1'b1;
        end

        if (cmd.add_wr)
        begin
            live_next[fill_reg[IW-1:0]] = 1'b1;
            fill_next = fill_reg + 1'b1;
        end
        if (cmd.del_kill)
        begin
            live_next = live_reg & ~child_reg;
            live_next[found_idx_reg] = 1'b0;
        end
        // fill_reg already points at the vacated last slot here
        if (cmd.mov_wr)
        begin
            live_next[fill_reg[IW-1:0]] = 1'b0;
            live_next[idx_reg[IW-1:0]]  = moved_live;
        end
        if (cmd.fill_dec)
            fill_next = fill_m1;

        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            fill_reg      <= '0;
            idx_reg       <= '0;
            live_reg      <= '0;
            child_reg     <= '0;
            found_reg     <= 1'b0;
            pfound_reg    <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            fill_reg    <= fill_next;
            idx_reg     <= idx_next;
            live_reg    <= live_next;
            child_reg   <= child_next;
            found_reg   <= found_next;
            pfound_reg  <= pfound_next;
            cmp_vld_reg <= cmd.cmp_arm;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result fields
    logic [CW-1:0]     slot_sel_val;
    logic [31:0]       slot_wide;
    always_comb
    begin
        unique case (cmd.slot_sel)
            SS_FILL:  slot_sel_val = fill_reg;
            SS_FOUND: slot_sel_val = CW'(found_idx_reg);
            SS_IDX:   slot_sel_val = idx_reg;
            default:  slot_sel_val = '0;
        endcase
        slot_wide = 32'(slot_sel_val);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            key_reg  <= in_key;
            par_reg  <= in_parent;
            info_reg <= in_info;
        end
        cmp_idx_reg   <= idx_reg[IW-1:0];
        found_idx_reg <= found_idx_next;
        fpar_reg      <= fpar_next;
        finfo_reg     <= finfo_next;
        if (cmd.emit)
        begin
            ostat_reg <= cmd.emit_status;
            oslot_reg <= slot_wide[SLOT_W-1:0];
            olast_reg <= cmd.emit_last;
            unique case (cmd.emit_kind)
                EK_INPUT:
                begin
                    okey_reg  <= key_reg;
                    opar_reg  <= par_reg;
                    oinfo_reg <= info_reg;
                    oev_reg   <= 1'b1;
                end
                EK_FOUND:
                begin
                    okey_reg  <= key_reg;
                    opar_reg  <= fpar_reg;
                    oinfo_reg <= finfo_reg;
                    oev_reg   <= 1'b1;
                end
                EK_RAM:
                begin
                    okey_reg  <= rd_key;
                    opar_reg  <= rd_par;
                    oinfo_reg <= rd_info;
                    oev_reg   <= 1'b1;
                end
                default:
                begin
                    okey_reg  <= '0;
                    opar_reg  <= '0;
                    oinfo_reg <= '0;
                    oev_reg   <= 1'b0;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = ostat_reg;
    assign out_slot        = oslot_reg;
    assign out_key         = okey_reg;
    assign out_parent      = opar_reg;
    assign out_info        = oinfo_reg;
    assign out_entry_valid = oev_reg;
    assign out_last        = olast_reg;

endmodule

// ===== sv/parent_linked_key_table.sv =====
`timescale 1ns / 1ps
// Key table with parent links, up to TABLE_DEPTH slots filled in order.
// req channel: one command per request (add, find, delete, compact, show)
// with key, parent key and info handle; codes 5..7 are taken and dropped.
// rsp channel: one result for add/find/delete/compact, one per live entry
// for show (one status result when none is live); last_result marks the final result of a command.
// cfg_we/cfg_wdata set the capacity limit (reset 32); write only when idle.
// add/find/delete scan the used slots one per cycle through the table RAM
// read port before the result. Compact steps past live slots and moves the
// last slot into each dead slot; show reads each live slot, emits it and
// skips dead slots. One command is in work at a time; req.ready is high
// only between commands.
// Results sit in an output register; a stalled receiver holds the
// controller until the register drains, nothing is dropped.
// Reset empties the table (fill count, live bits) and sets the capacity
// limit to 32 at once; no clearing pass.
module parent_linked_key_table import plkt_pkg::*; #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    plkt_req_if.sink         req,
    plkt_rsp_if.source       rsp,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    plkt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_ready   (req.ready),
        .req_command (req.command),
        .stat        (stat),
        .cmd         (cmd)
    );

    plkt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_key          (req.entry_key_in),
        .in_parent       (req.parent_key_in),
        .in_info         (req.info_handle_in),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (rsp.ready),
        .out_valid       (rsp.valid),
        .out_status      (rsp.status),
        .out_slot        (rsp.slot_index),
        .out_key         (rsp.out_key),
        .out_parent      (rsp.out_parent),
        .out_info        (rsp.out_info),
        .out_entry_valid (rsp.entry_valid),
        .out_last        (rsp.last_result)
    );

endmodule

// ===== sv/plkt_chk.sv =====
`timescale 1ns / 1ps
`include "parent_linked_key_table_assert.svh"
module plkt_chk import plkt_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [STAT_W-1:0] rsp_status,
    input logic              rsp_entry_valid,
    input logic              rsp_last_result
);

    // a stalled result stays offered
    `PLKT_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    // an accepted request leaves the block busy in the cycle after
    `PLKT_ASSERT_NXT(a_busy_after_req, clk, rst_n, req_valid && req_ready, !req_ready)
    // a non-final result on offer means the command is still in work
    `PLKT_ASSERT_IMP(a_more_pending, clk, rst_n, rsp_valid && !rsp_last_result, !req_ready)
    // entry data only comes with an ok status
    `PLKT_ASSERT_IMP(a_entry_ok, clk, rst_n, rsp_valid && rsp_entry_valid,
        rsp_status == ST_OK)

endmodule

bind parent_linked_key_table plkt_chk u_plkt_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_valid (rsp.entry_valid),
    .rsp_last_result (rsp.last_result)
);

// ===== verif/plkt_tb_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces come from the RTL tree (plkt_req_if, plkt_rsp_if);
// this file holds the request and result record types used by the bench.
package plkt_tb_types;
    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] entry_key;
        logic [31:0] parent_key;
        logic [15:0] info_handle;
    } table_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot_index;
        logic [31:0] out_key;
        logic [31:0] out_parent;
        logic [15:0] out_info;
        logic        entry_valid;
        logic        last_result;
    } table_rsp_t;
endpackage

// ===== verif/tb_parent_linked_key_table.sv =====
`timescale 1ns / 1ps
module tb_parent_linked_key_table;
    import plkt_pkg::*;
    import plkt_tb_types::*;

    localparam int DEPTH = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    // Shadow table: predicts every result of an accepted request
    class key_table_scoreboard;
        logic [31:0] shadow_key [DEPTH];
        logic [31:0] shadow_parent [DEPTH];
        logic [15:0] shadow_info [DEPTH];
        bit          shadow_live [DEPTH];
        int          used_slots;
        int          cap_limit;
        table_rsp_t  pending [$];
        int          error_count;

        function new();
            used_slots = 0;
            cap_limit = 32;
            error_count = 0;
            foreach (shadow_live[i]) shadow_live[i] = 0;
        endfunction

        function int lookup_live(logic [31:0] key);
            for (int i = 0; i < used_slots; i++)
                if (shadow_live[i] && shadow_key[i] == key) return i;
            return -1;
        endfunction

        function void push_result(logic [2:0] st, int slot, bit with_entry, bit last);
            table_rsp_t r;
            r.status = st;
            r.slot_index = (slot >= 0) ? slot[4:0] : 5'd0;
            r.out_key = with_entry ? shadow_key[slot] : 32'd0;
            r.out_parent = with_entry ? shadow_parent[slot] : 32'd0;
            r.out_info = with_entry ? shadow_info[slot] : 16'd0;
            r.entry_valid = with_entry;
            r.last_result = last;
            pending.push_back(r);
        endfunction

        // Note an accepted request and queue its expected results
        function void note_request(table_req_t q);
            int cap, p, lastlive;
            cap = (cap_limit < DEPTH) ? cap_limit : DEPTH;
            case (q.command)
                OP_ADD:
                begin
                    if (lookup_live(q.entry_key) >= 0) push_result(ST_DUPLICATE, -1, 0, 1);
                    else if (q.parent_key != 0 && lookup_live(q.parent_key) < 0)
                        push_result(ST_NO_PARENT, -1, 0, 1);
                    else if (used_slots >= cap) push_result(ST_FULL, -1, 0, 1);
                    else
                    begin
                        p = used_slots;
                        shadow_key[p] = q.entry_key;
                        shadow_parent[p] = q.parent_key;
                        shadow_info[p] = q.info_handle;
                        shadow_live[p] = 1;
                        used_slots++;
                        push_result(ST_OK, p, 1, 1);
                    end
                end
                OP_FIND:
                begin
                    p = lookup_live(q.entry_key);
                    if (p < 0) push_result(ST_NOT_FOUND, -1, 0, 1);
                    else push_result(ST_OK, p, 1, 1);
                end
                OP_DELETE:
                begin
                    p = lookup_live(q.entry_key);
                    if (used_slots == 0) push_result(ST_EMPTY, -1, 0, 1);
                    else if (p < 0) push_result(ST_NOT_FOUND, -1, 0, 1);
                    else
                    begin
                        shadow_live[p] = 0;
                        for (int i = 0; i < used_slots; i++)
                            if (shadow_parent[i] == q.entry_key) shadow_live[i] = 0;
                        push_result(ST_OK, p, 0, 1);
                    end
                end
                OP_COMPACT:
                begin
                    if (used_slots == 0) push_result(ST_EMPTY, -1, 0, 1);
                    else
                    begin
                        p = 0;
                        while (p < used_slots)
                        begin
                            if (!shadow_live[p])
                            begin
                                used_slots--;
                                shadow_key[p] = shadow_key[used_slots];
                                shadow_parent[p] = shadow_parent[used_slots];
                                shadow_info[p] = shadow_info[used_slots];
                                shadow_live[p] = shadow_live[used_slots];
                                if (used_slots != p) shadow_live[used_slots] = 0;
                            end
                            else p++;
                        end
                        push_result(ST_OK, -1, 0, 1);
                    end
                end
                OP_SHOW:
                begin
                    lastlive = -1;
                    for (int i = 0; i < used_slots; i++)
                        if (shadow_live[i]) lastlive = i;
                    if (used_slots == 0) push_result(ST_EMPTY, -1, 0, 1);
                    else if (lastlive < 0) push_result(ST_OK, -1, 0, 1);
                    else
                        for (int i = 0; i < used_slots; i++)
                            if (shadow_live[i]) push_result(ST_OK, i, 1, i == lastlive);
                end
                default: ;
            endcase
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(table_rsp_t got);
            table_rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result st=%0d key=%h", $time, got.status, got.out_key);
                error_count++;
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                $display("%0t: mismatch exp st=%0d slot=%0d key=%h par=%h info=%h ev=%b last=%b",
                         $time, e.status, e.slot_index, e.out_key, e.out_parent,
                         e.out_info, e.entry_valid, e.last_result);
                $display("%0t:          got st=%0d slot=%0d key=%h par=%h info=%h ev=%b last=%b",
                         $time, got.status, got.slot_index, got.out_key, got.out_parent,
                         got.out_info, got.entry_valid, got.last_result);
                error_count++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic [CAP_W-1:0] cfg_wdata = '0;

    plkt_req_if req ();
    plkt_rsp_if rsp ();

    parent_linked_key_table #(.TABLE_DEPTH(DEPTH)) uut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    key_table_scoreboard sb = new();
    int idle_cycles = 0;
    bit hold_off = 0;
    bit stimulus_done = 0;
    logic [31:0] key_pool [$];

    initial
    begin
        req.valid = 0;
        req.command = '0;
        req.entry_key_in = '0;
        req.parent_key_in = '0;
        req.info_handle_in = '0;
        rsp.ready = 0;
    end

    // Accept monitor and watchdog on the rising edge
    always @(posedge clk)
    begin
        table_req_t q;
        table_rsp_t r;
        if (rst_n)
        begin
            idle_cycles++;
            if (req.valid && req.ready)
            begin
                q.command = req.command;
                q.entry_key = req.entry_key_in;
                q.parent_key = req.parent_key_in;
                q.info_handle = req.info_handle_in;
                sb.note_request(q);
                idle_cycles = 0;
            end
            if (rsp.valid && rsp.ready)
            begin
                r.status = rsp.status;
                r.slot_index = rsp.slot_index;
                r.out_key = rsp.out_key;
                r.out_parent = rsp.out_parent;
                r.out_info = rsp.out_info;
                r.entry_valid = rsp.entry_valid;
                r.last_result = rsp.last_result;
                sb.check_result(r);
                idle_cycles = 0;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: random stalls, long hold-off on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp.ready <= 0;
                repeat (150) @(negedge clk);
                hold_off = 0;
            end
            if (stimulus_done) rsp.ready <= 1;
            else
            begin
                g = gap_len();
                if (g == 0) rsp.ready <= 1;
                else
                begin
                    rsp.ready <= 0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    // Valid stays high into the next request when there is no gap
    task automatic send_request(logic [2:0] cmd, logic [31:0] key, logic [31:0] par,
                                logic [15:0] info);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 0;
            repeat (g) @(negedge clk);
        end
        req.valid <= 1;
        req.command <= cmd;
        req.entry_key_in <= key;
        req.parent_key_in <= par;
        req.info_handle_in <= info;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
        if (cmd == OP_ADD) key_pool.push_back(key);
    endtask

    task automatic settle_and_configure(logic [CAP_W-1:0] cap);
        req.valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        cfg_we <= 1;
        cfg_wdata <= cap;
        sb.cap_limit = cap;
        @(negedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [31:0] pick_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return $urandom;
    endfunction

    // Random phase: mostly adds and lookups on known keys
    task automatic random_phase(int n);
        int roll;
        logic [31:0] par;
        for (int i = 0; i < n; i++)
        begin
            roll = $urandom_range(0, 99);
            par = ($urandom_range(0, 2) == 0) ? 32'd0 : pick_key();
            if (roll < 40) send_request(OP_ADD, $urandom, par, 16'($urandom));
            else if (roll < 58) send_request(OP_FIND, pick_key(), 32'd0, 16'd0);
            else if (roll < 74) send_request(OP_DELETE, pick_key(), 32'd0, 16'd0);
            else if (roll < 82) send_request(OP_COMPACT, $urandom, $urandom, 16'($urandom));
            else if (roll < 95) send_request(OP_SHOW, $urandom, $urandom, 16'($urandom));
            else send_request(3'($urandom_range(5, 7)), $urandom, $urandom, 16'($urandom));
        end
    endtask

    initial
    begin
        int wait_cycles;
        repeat (2) @(negedge clk);
        rst_n = 1;

        // Directed: empty table cases, extremes of the fields
        send_request(OP_SHOW, 32'd1, 32'd0, 16'd0);
        send_request(OP_DELETE, 32'd1, 32'd0, 16'd0);
        send_request(OP_COMPACT, 32'd1, 32'd0, 16'd0);
        send_request(OP_FIND, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'd0, 16'h0000);
        send_request(OP_ADD, 32'd0, 32'hFFFF_FFFF, 16'h0000);
        send_request(OP_ADD, 32'd7, 32'h1234_5678, 16'h5A5A);
        send_request(OP_ADD, 32'hA5A5_A5A5, 32'd0, 16'hA5A5);
        send_request(OP_FIND, 32'd0, 32'd0, 16'd0);
        send_request(OP_SHOW, 32'd0, 32'd0, 16'd0);
        send_request(3'd5, 32'd1, 32'd1, 16'd1);
        send_request(3'd7, 32'd1, 32'd1, 16'd1);
        send_request(OP_DELETE, 32'hFFFF_FFFF, 32'd0, 16'd0);
        send_request(OP_DELETE, 32'd99, 32'd0, 16'd0);
        send_request(OP_SHOW, 32'd0, 32'd0, 16'd0);
        send_request(OP_COMPACT, 32'd0, 32'd0, 16'd0);
        send_request(OP_DELETE, 32'hA5A5_A5A5, 32'd0, 16'd0);
        send_request(OP_SHOW, 32'd0, 32'd0, 16'd0);
        send_request(OP_COMPACT, 32'd0, 32'd0, 16'd0);

        // Small capacity, including a limit below the fill count
        settle_and_configure(6'd1);
        send_request(OP_ADD, 32'h5555_5555, 32'd0, 16'h1);
        send_request(OP_ADD, 32'h6666_6666, 32'd0, 16'h2);
        settle_and_configure(6'd0);
        random_phase(30);
        settle_and_configure(6'd63);

        // Long receiver stall while adds keep coming
        hold_off = 1;
        random_phase(100);
        settle_and_configure(6'd5);
        random_phase(40);
        settle_and_configure(6'd32);
        random_phase(70);

        req.valid <= 0;
        stimulus_done = 1;
        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 10000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (100) @(negedge clk);
        if (sb.error_count == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// ===== parent_linked_key_table.f =====
+incdir+sv
sv/plkt_pkg.sv
sv/plkt_req_if.sv
sv/plkt_rsp_if.sv
sv/plkt_ram.sv
sv/plkt_ctrl.sv
sv/plkt_dp.sv
sv/parent_linked_key_table.sv
sv/plkt_chk.sv
verif/plkt_tb_if.sv
verif/tb_parent_linked_key_table.sv
